### hdl/rwsd_pkg.sv
// ----------------------------------------------------------------------------
// rwsd_pkg
// Shared codes, result and handshake types of the RIFF/WAVE stream decoder.
// ----------------------------------------------------------------------------
package rwsd_pkg;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_CHUNK  = 2'd1;
	localparam logic [1:0] PH_BODY   = 2'd2;
	localparam logic [1:0] PH_END    = 2'd3;

	localparam logic [1:0] KIND_FRAME = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [2:0] ERR_NONE        = 3'd0;
	localparam logic [2:0] ERR_MALFORMED   = 3'd1;
	localparam logic [2:0] ERR_UNSUPPORTED = 3'd2;
	localparam logic [2:0] ERR_EMPTY       = 3'd3;
	localparam logic [2:0] ERR_TOO_LONG    = 3'd4;
	localparam logic [2:0] ERR_NON_FINITE  = 3'd5;

	localparam logic [31:0] ID_RIFF = 32'h4646_4952;
	localparam logic [31:0] ID_WAVE = 32'h4556_4157;
	localparam logic [31:0] ID_FMT  = 32'h2074_6d66;
	localparam logic [31:0] ID_DATA = 32'h6174_6164;

	localparam logic [15:0] TAG_PCM        = 16'd1;
	localparam logic [15:0] TAG_FLOAT      = 16'd3;
	localparam logic [15:0] TAG_EXTENSIBLE = 16'hfffe;
	localparam logic [31:0] MAX_RATE       = 32'd384000;
	localparam logic [31:0] FMT_MIN_SIZE   = 32'd16;
	localparam logic [31:0] EXT_MIN_SIZE   = 32'd40;
	localparam logic [31:0] EXT_CB_FIELD   = 32'd18;
	localparam logic [15:0] EXT_MIN_CB     = 16'd22;
	localparam logic [15:0] MAX_DUR_RESET  = 16'd480;

	// Follow-up step requested by the datapath for the current byte.
	localparam logic [2:0] NX_LAST = 3'd0;
	localparam logic [2:0] NX_BND  = 3'd1;
	localparam logic [2:0] NX_HEAD = 3'd2;
	localparam logic [2:0] NX_FMTV = 3'd3;
	localparam logic [2:0] NX_DMUL = 3'd4;
	localparam logic [2:0] NX_DCMP = 3'd5;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] left_sample;
		logic [31:0] right_sample;
		logic        is_float;
		logic [2:0]  error_code;
		logic [31:0] frame_total;
		logic [18:0] sample_rate;
		logic        last_of_run;
	} result_t;

	typedef struct packed {
		logic latch;
		logic step;
		logic head;
		logic dmul;
		logic dcmp;
		logic fmtv;
		logic bnd;
		logic last;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic       can_gen;
		logic       pend_valid;
		logic       out_free;
		logic [2:0] nx;
	} sts_t;

	// Last twelve bytes of the extensible sub-format GUID.
	function automatic logic [7:0] guid_tail_byte(input logic [3:0] i);
		logic [7:0] r;
		case (i)
			4'd2:    r = 8'h10;
			4'd4:    r = 8'h80;
			4'd7:    r = 8'haa;
			4'd9:    r = 8'h38;
			4'd10:   r = 8'h9b;
			4'd11:   r = 8'h71;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

### hdl/rwsd_if.sv
// ----------------------------------------------------------------------------
// rwsd_if
// Valid/ready channels for file bytes in and decoded results out.
// ----------------------------------------------------------------------------
interface rwsd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] file_byte;
	logic       is_last;
	modport source(output valid, file_byte, is_last, input ready);
	modport sink(input valid, file_byte, is_last, output ready);
endinterface

interface rwsd_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] left_sample;
	logic [31:0] right_sample;
	logic        is_float;
	logic [2:0]  error_code;
	logic [31:0] frame_total;
	logic [18:0] sample_rate;
	logic        last_of_run;
	modport source(output valid, kind, left_sample, right_sample, is_float, error_code,
		frame_total, sample_rate, last_of_run, input ready);
	modport sink(input valid, kind, left_sample, right_sample, is_float, error_code,
		frame_total, sample_rate, last_of_run, output ready);
endinterface

### hdl/rwsd_ctrl.sv
// ----------------------------------------------------------------------------
// rwsd_ctrl
// Per-byte sequencer: accepts a byte, then steps the datapath through the
// checks that the byte triggers, and finally flushes the held result.
// ----------------------------------------------------------------------------
module rwsd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  rwsd_pkg::sts_t  sts,
	output rwsd_pkg::cmd_t  cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_STEP  = 4'd1;
	localparam logic [3:0] S_HEAD  = 4'd2;
	localparam logic [3:0] S_DMUL  = 4'd3;
	localparam logic [3:0] S_DCMP  = 4'd4;
	localparam logic [3:0] S_FMTV  = 4'd5;
	localparam logic [3:0] S_BND   = 4'd6;
	localparam logic [3:0] S_LAST  = 4'd7;
	localparam logic [3:0] S_FLUSH = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	function automatic logic [3:0] follow(input logic [2:0] nx);
		logic [3:0] s;
		case (nx)
			rwsd_pkg::NX_BND:  s = S_BND;
			rwsd_pkg::NX_HEAD: s = S_HEAD;
			rwsd_pkg::NX_FMTV: s = S_FMTV;
			rwsd_pkg::NX_DMUL: s = S_DMUL;
			rwsd_pkg::NX_DCMP: s = S_DCMP;
			default:           s = S_LAST;
		endcase
		return s;
	endfunction

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_STEP;
				end
			end
			S_STEP: if (sts.can_gen) begin
				cmd.step = 1'b1;
				state_d  = follow(sts.nx);
			end
			S_HEAD: if (sts.can_gen) begin
				cmd.head = 1'b1;
				state_d  = follow(sts.nx);
			end
			S_DMUL: if (sts.can_gen) begin
				cmd.dmul = 1'b1;
				state_d  = follow(sts.nx);
			end
			S_DCMP: if (sts.can_gen) begin
				cmd.dcmp = 1'b1;
				state_d  = follow(sts.nx);
			end
			S_FMTV: if (sts.can_gen) begin
				cmd.fmtv = 1'b1;
				state_d  = follow(sts.nx);
			end
			S_BND: if (sts.can_gen) begin
				cmd.bnd = 1'b1;
				state_d = follow(sts.nx);
			end
			S_LAST: if (sts.can_gen) begin
				cmd.last = 1'b1;
				state_d  = S_FLUSH;
			end
			S_FLUSH: begin
				cmd.flush = 1'b1;
				if (!sts.pend_valid || sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### hdl/rwsd_dp.sv
// ----------------------------------------------------------------------------
// rwsd_dp
// Datapath: file position, chunk walk, format fields, sample assembly,
// duration check, and the held and output result registers.
// ----------------------------------------------------------------------------
module rwsd_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data,
	input  logic [7:0]         file_byte,
	input  logic               is_last,
	input  rwsd_pkg::cmd_t     cmd,
	output rwsd_pkg::sts_t     sts,
	input  logic               out_ready,
	output logic               out_valid,
	output rwsd_pkg::result_t  out_res
);

	logic [15:0] max_dur_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic [1:0]  phase_q;
	logic [32:0] bpos_q;
	logic [32:0] riff_end_q;
	logic [31:0] cid_q;
	logic [31:0] csize_q;
	logic [32:0] crem_q;
	logic [32:0] bidx_q;
	logic [15:0] fmt_tag_q;
	logic [15:0] fmt_ch_q;
	logic [15:0] fmt_align_q;
	logic [15:0] fmt_bits_q;
	logic [15:0] fmt_ext_q;
	logic [15:0] fmt_vbits_q;
	logic [31:0] rate_q;
	logic [31:0] brate_q;
	logic [31:0] subfmt_q;
	logic        guid_ok_q;
	logic        fmt_seen_q;
	logic        data_seen_q;
	logic [31:0] asm_q;
	logic [31:0] lhold_q;
	logic [1:0]  bis_q;
	logic        chan_q;
	logic [31:0] fcnt_q;
	logic [34:0] lim_q;
	logic        pend_valid_q;
	rwsd_pkg::result_t pend_q;
	logic        out_valid_q;
	rwsd_pkg::result_t out_q;

	function automatic logic [31:0] put_lane(input logic [31:0] w, input logic [1:0] k,
		input logic [7:0] b);
		return w | ({24'd0, b} << {k, 3'b000});
	endfunction

	// Divisibility by three: 256 is one modulo three, so fold bytes, then bit pairs.
	function automatic logic div3(input logic [31:0] x);
		logic [9:0] s1;
		logic [3:0] s2;
		logic       r;
		s1 = 10'(x[7:0]) + 10'(x[15:8]) + 10'(x[23:16]) + 10'(x[31:24]);
		s2 = 4'(s1[1:0]) + 4'(s1[3:2]) + 4'(s1[5:4]) + 4'(s1[7:6]) + 4'(s1[9:8]);
		case (s2) inside
			4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: r = 1'b1;
			default:                              r = 1'b0;
		endcase
		return r;
	endfunction

	logic [31:0] hdr_id_new, hdr_size_new;
	logic [32:0] riff_new;
	logic        body_in, body_lastb, is_fmt, is_data, is_flt, stereo;
	logic [2:0]  bps;
	logic [31:0] asm_new, v_pcm, smp_v;
	logic        smp_done, smp_nonfinite;
	logic [32:0] padded;
	logic        over, bnd_eq, bnd_bad, mod_bad, too_long, fmt_bad;
	logic [38:0] prod2;
	logic [3:0]  exp_align;
	logic [22:0] exp_rate;
	logic [15:0] ext_eff;
	logic [31:0] tag_eff;
	logic        ext_bad, pcm_ok, flt_ok;
	logic [5:0]  gidx;
	logic        out_free, can_gen;
	logic        fail, frame, done, gen, clr;
	logic [2:0]  fail_code;
	logic [2:0]  nx;
	rwsd_pkg::result_t gen_res;

	assign hdr_id_new   = put_lane(cid_q, bpos_q[1:0], byte_q);
	assign hdr_size_new = put_lane(csize_q, bpos_q[1:0], byte_q);
	assign riff_new     = {1'b0, hdr_size_new} + 33'd8;
	assign body_in      = bidx_q < {1'b0, csize_q};
	assign body_lastb   = bidx_q == ({1'b0, csize_q} - 33'd1);
	assign is_fmt       = cid_q == rwsd_pkg::ID_FMT;
	assign is_data      = cid_q == rwsd_pkg::ID_DATA;
	assign is_flt       = (fmt_tag_q == rwsd_pkg::TAG_EXTENSIBLE) ?
		(subfmt_q == {16'd0, rwsd_pkg::TAG_FLOAT}) : (fmt_tag_q == rwsd_pkg::TAG_FLOAT);
	assign stereo       = fmt_ch_q == 16'd2;
	assign bps          = fmt_bits_q[5:3];
	assign gidx         = bidx_q[5:0] - 6'd28;

	assign asm_new       = put_lane(asm_q, bis_q, byte_q);
	assign smp_done      = ({1'b0, bis_q} + 3'd1) >= bps;
	assign smp_nonfinite = is_flt && (asm_new[30:23] == 8'hff);

	always_comb begin
		case (bps)
			3'd2:    v_pcm = {asm_new[15:0], 16'd0};
			3'd3:    v_pcm = {asm_new[23:0], 8'd0};
			default: v_pcm = asm_new;
		endcase
	end
	assign smp_v = is_flt ? asm_new : v_pcm;

	assign padded  = {1'b0, csize_q} + {32'd0, csize_q[0]};
	assign over    = ({1'b0, bpos_q} + {1'b0, padded}) > {1'b0, riff_end_q};
	assign bnd_eq  = bpos_q == riff_end_q;
	assign bnd_bad = ({1'b0, bpos_q} + 34'd8) > {1'b0, riff_end_q};

	// Block alignment is one of 2, 3, 4, 6 or 8 once the format has passed.
	always_comb begin
		case (fmt_align_q)
			16'd2:   mod_bad = csize_q[0];
			16'd3:   mod_bad = !div3(csize_q);
			16'd4:   mod_bad = csize_q[1:0] != 2'd0;
			16'd6:   mod_bad = csize_q[0] || !div3(csize_q);
			16'd8:   mod_bad = csize_q[2:0] != 3'd0;
			default: mod_bad = 1'b1;
		endcase
	end

	// The data is whole blocks here, so frames exceed the limit exactly when
	// the size exceeds limit times alignment.
	assign prod2    = 39'(lim_q) * 39'(fmt_align_q[3:0]);
	assign too_long = {7'd0, csize_q} > prod2;

	assign ext_eff   = (csize_q >= EXT_CB_FIELD_C) ? fmt_ext_q : 16'd0;
	localparam logic [31:0] EXT_CB_FIELD_C = rwsd_pkg::EXT_CB_FIELD;
	assign ext_bad   = (fmt_tag_q == rwsd_pkg::TAG_EXTENSIBLE) &&
		(csize_q < rwsd_pkg::EXT_MIN_SIZE || ext_eff < rwsd_pkg::EXT_MIN_CB ||
		({16'd0, ext_eff} + rwsd_pkg::EXT_CB_FIELD) > csize_q || !guid_ok_q ||
		fmt_vbits_q != fmt_bits_q || subfmt_q[31:16] != 16'd0);
	assign tag_eff   = (fmt_tag_q == rwsd_pkg::TAG_EXTENSIBLE) ? subfmt_q : {16'd0, fmt_tag_q};
	assign pcm_ok    = tag_eff == {16'd0, rwsd_pkg::TAG_PCM} &&
		(fmt_bits_q == 16'd16 || fmt_bits_q == 16'd24 || fmt_bits_q == 16'd32);
	assign flt_ok    = tag_eff == {16'd0, rwsd_pkg::TAG_FLOAT} && fmt_bits_q == 16'd32;
	assign exp_align = (fmt_ch_q == 16'd2) ? {bps, 1'b0} : {1'b0, bps};
	assign exp_rate  = 23'(rate_q[18:0]) * 23'(exp_align);
	assign fmt_bad   = ext_bad || !(pcm_ok || flt_ok) ||
		!(fmt_ch_q == 16'd1 || fmt_ch_q == 16'd2) ||
		rate_q == 32'd0 || rate_q > rwsd_pkg::MAX_RATE ||
		fmt_align_q != {12'd0, exp_align} || brate_q != {9'd0, exp_rate};

	assign out_free = !out_valid_q || out_ready;
	assign can_gen  = !pend_valid_q || out_free;
	assign clr      = cmd.last && last_q;

	always_comb begin
		fail      = 1'b0;
		fail_code = rwsd_pkg::ERR_NONE;
		frame     = 1'b0;
		done      = 1'b0;
		nx        = rwsd_pkg::NX_LAST;
		if (cmd.step) begin
			case (phase_q)
				rwsd_pkg::PH_HEADER: begin
					case (bpos_q[3:0])
						4'd3: if (hdr_id_new != rwsd_pkg::ID_RIFF) begin
							fail = 1'b1;
						end
						4'd7: if (riff_new < 33'd12) begin
							fail = 1'b1;
						end
						4'd11: begin
							if (hdr_id_new != rwsd_pkg::ID_WAVE) begin
								fail = 1'b1;
							end else begin
								nx = rwsd_pkg::NX_BND;
							end
						end
						default: ;
					endcase
					fail_code = rwsd_pkg::ERR_MALFORMED;
				end
				rwsd_pkg::PH_CHUNK: if (crem_q[2:0] == 3'd7) begin
					nx = rwsd_pkg::NX_HEAD;
				end
				rwsd_pkg::PH_BODY: begin
					if (body_in && is_fmt && body_lastb) begin
						nx = rwsd_pkg::NX_FMTV;
					end else begin
						if (body_in && is_data && smp_done) begin
							if (smp_nonfinite) begin
								fail      = 1'b1;
								fail_code = rwsd_pkg::ERR_NON_FINITE;
							end else if (!(stereo && !chan_q)) begin
								frame = 1'b1;
							end
						end
						if (!fail && crem_q == 33'd1) begin
							nx = rwsd_pkg::NX_BND;
						end
					end
				end
				default: ;
			endcase
		end
		if (cmd.head) begin
			fail_code = rwsd_pkg::ERR_MALFORMED;
			if (over) begin
				fail = 1'b1;
			end else if (is_fmt) begin
				fail = fmt_seen_q || csize_q < rwsd_pkg::FMT_MIN_SIZE;
			end else if (is_data) begin
				if (!fmt_seen_q || data_seen_q) begin
					fail = 1'b1;
				end else if (csize_q == 32'd0) begin
					fail      = 1'b1;
					fail_code = rwsd_pkg::ERR_EMPTY;
				end else begin
					nx = rwsd_pkg::NX_DMUL;
				end
			end else if (padded == 33'd0) begin
				nx = rwsd_pkg::NX_BND;
			end
		end
		if (cmd.dmul) begin
			fail_code = rwsd_pkg::ERR_MALFORMED;
			if (mod_bad) begin
				fail = 1'b1;
			end else begin
				nx = rwsd_pkg::NX_DCMP;
			end
		end
		if (cmd.dcmp) begin
			fail      = too_long;
			fail_code = rwsd_pkg::ERR_TOO_LONG;
		end
		if (cmd.fmtv) begin
			fail_code = rwsd_pkg::ERR_UNSUPPORTED;
			if (fmt_bad) begin
				fail = 1'b1;
			end else if (crem_q == 33'd0) begin
				nx = rwsd_pkg::NX_BND;
			end
		end
		if (cmd.bnd) begin
			fail_code = rwsd_pkg::ERR_MALFORMED;
			if (bnd_eq) begin
				if (!fmt_seen_q || !data_seen_q) begin
					fail = 1'b1;
				end else begin
					done = 1'b1;
				end
			end else begin
				fail = bnd_bad;
			end
		end
		if (cmd.last) begin
			fail_code = rwsd_pkg::ERR_MALFORMED;
			fail      = last_q && phase_q != rwsd_pkg::PH_END;
		end
	end

	assign gen = fail || frame || done;

	always_comb begin
		gen_res = '0;
		if (fail) begin
			gen_res.kind       = rwsd_pkg::KIND_ERROR;
			gen_res.error_code = fail_code;
		end else if (done) begin
			gen_res.kind        = rwsd_pkg::KIND_DONE;
			gen_res.is_float    = is_flt;
			gen_res.frame_total = fcnt_q;
			gen_res.sample_rate = rate_q[18:0];
		end else begin
			gen_res.kind         = rwsd_pkg::KIND_FRAME;
			gen_res.left_sample  = stereo ? lhold_q : smp_v;
			gen_res.right_sample = smp_v;
			gen_res.is_float     = is_flt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dur_q   <= rwsd_pkg::MAX_DUR_RESET;
			byte_q      <= '0;
			last_q      <= 1'b0;
			phase_q     <= rwsd_pkg::PH_HEADER;
			bpos_q      <= '0;
			riff_end_q  <= '0;
			cid_q       <= '0;
			csize_q     <= '0;
			crem_q      <= '0;
			bidx_q      <= '0;
			fmt_tag_q   <= '0;
			fmt_ch_q    <= '0;
			fmt_align_q <= '0;
			fmt_bits_q  <= '0;
			fmt_ext_q   <= '0;
			fmt_vbits_q <= '0;
			rate_q      <= '0;
			brate_q     <= '0;
			subfmt_q    <= '0;
			guid_ok_q   <= 1'b1;
			fmt_seen_q  <= 1'b0;
			data_seen_q <= 1'b0;
			asm_q       <= '0;
			lhold_q     <= '0;
			bis_q       <= '0;
			chan_q      <= 1'b0;
			fcnt_q      <= '0;
			lim_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				max_dur_q <= cfg_wr_data;
			end
			if (cmd.latch) begin
				byte_q <= file_byte;
				last_q <= is_last;
			end
			if (cmd.step) begin
				case (phase_q)
					rwsd_pkg::PH_HEADER: begin
						bpos_q <= bpos_q + 33'd1;
						if (bpos_q[3:2] == 2'b01) begin
							csize_q <= hdr_size_new;
						end else begin
							cid_q <= hdr_id_new;
						end
						if (bpos_q[3:0] == 4'd3) begin
							cid_q <= '0;
						end
						if (bpos_q[3:0] == 4'd7) begin
							riff_end_q <= riff_new;
						end
					end
					rwsd_pkg::PH_CHUNK: begin
						bpos_q <= bpos_q + 33'd1;
						if (crem_q[2]) begin
							csize_q <= put_lane(csize_q, crem_q[1:0], byte_q);
						end else begin
							cid_q <= put_lane(cid_q, crem_q[1:0], byte_q);
						end
						crem_q <= {30'd0, crem_q[2:0]} + 33'd1;
					end
					rwsd_pkg::PH_BODY: begin
						bpos_q <= bpos_q + 33'd1;
						crem_q <= crem_q - 33'd1;
						bidx_q <= bidx_q + 33'd1;
						if (body_in && is_fmt && bidx_q < 33'd40) begin
							case (bidx_q[5:0]) inside
								6'd0:  fmt_tag_q[7:0]    <= byte_q;
								6'd1:  fmt_tag_q[15:8]   <= byte_q;
								6'd2:  fmt_ch_q[7:0]     <= byte_q;
								6'd3:  fmt_ch_q[15:8]    <= byte_q;
								[6'd4:6'd7]:   rate_q <= put_lane(rate_q, bidx_q[1:0], byte_q);
								[6'd8:6'd11]:  brate_q <= put_lane(brate_q, bidx_q[1:0], byte_q);
								6'd12: fmt_align_q[7:0]  <= byte_q;
								6'd13: fmt_align_q[15:8] <= byte_q;
								6'd14: fmt_bits_q[7:0]   <= byte_q;
								6'd15: fmt_bits_q[15:8]  <= byte_q;
								6'd16: fmt_ext_q[7:0]    <= byte_q;
								6'd17: fmt_ext_q[15:8]   <= byte_q;
								6'd18: fmt_vbits_q[7:0]  <= byte_q;
								6'd19: fmt_vbits_q[15:8] <= byte_q;
								[6'd24:6'd27]: subfmt_q <= put_lane(subfmt_q, bidx_q[1:0], byte_q);
								[6'd28:6'd39]: begin
									if (byte_q != rwsd_pkg::guid_tail_byte(gidx[3:0])) begin
										guid_ok_q <= 1'b0;
									end
								end
								default: ;
							endcase
						end
						if (body_in && is_data) begin
							if (!smp_done) begin
								asm_q <= asm_new;
								bis_q <= bis_q + 2'd1;
							end else begin
								asm_q <= '0;
								bis_q <= '0;
								if (!smp_nonfinite) begin
									if (stereo && !chan_q) begin
										lhold_q <= smp_v;
										chan_q  <= 1'b1;
									end else begin
										chan_q <= 1'b0;
										fcnt_q <= fcnt_q + 32'd1;
									end
								end
							end
						end
					end
					default: ;
				endcase
			end
			if (cmd.head && !fail) begin
				if (is_fmt) begin
					fmt_seen_q  <= 1'b1;
					fmt_tag_q   <= '0;
					fmt_ch_q    <= '0;
					fmt_align_q <= '0;
					fmt_bits_q  <= '0;
					fmt_ext_q   <= '0;
					fmt_vbits_q <= '0;
					rate_q      <= '0;
					brate_q     <= '0;
					subfmt_q    <= '0;
					guid_ok_q   <= 1'b1;
				end
				if (is_data) begin
					data_seen_q <= 1'b1;
				end else begin
					crem_q <= padded;
					bidx_q <= '0;
					if (padded != 33'd0) begin
						phase_q <= rwsd_pkg::PH_BODY;
					end
				end
			end
			if (cmd.dmul) begin
				lim_q <= 35'(max_dur_q) * 35'(rate_q[18:0]);
			end
			if (cmd.dcmp && !fail) begin
				crem_q  <= padded;
				bidx_q  <= '0;
				phase_q <= rwsd_pkg::PH_BODY;
				asm_q   <= '0;
				bis_q   <= '0;
				chan_q  <= 1'b0;
			end
			if (cmd.bnd && !fail && !bnd_eq) begin
				phase_q <= rwsd_pkg::PH_CHUNK;
				cid_q   <= '0;
				csize_q <= '0;
				crem_q  <= '0;
			end
			if (fail || done) begin
				phase_q <= rwsd_pkg::PH_END;
			end
			// End of file: the parse and format state starts afresh; the duration register keeps its value.
			if (clr) begin
				phase_q     <= rwsd_pkg::PH_HEADER;
				bpos_q      <= '0;
				riff_end_q  <= '0;
				cid_q       <= '0;
				csize_q     <= '0;
				crem_q      <= '0;
				bidx_q      <= '0;
				fmt_tag_q   <= '0;
				fmt_ch_q    <= '0;
				fmt_align_q <= '0;
				fmt_bits_q  <= '0;
				fmt_ext_q   <= '0;
				fmt_vbits_q <= '0;
				rate_q      <= '0;
				brate_q     <= '0;
				subfmt_q    <= '0;
				guid_ok_q   <= 1'b1;
				fmt_seen_q  <= 1'b0;
				data_seen_q <= 1'b0;
				asm_q       <= '0;
				lhold_q     <= '0;
				bis_q       <= '0;
				chan_q      <= 1'b0;
				fcnt_q      <= '0;
			end
		end
	end

	// One result is held back until it is known whether another follows for
	// the same byte; only then is its last-of-run flag settled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (gen && pend_valid_q) begin
				out_valid_q <= 1'b1;
			end else if (cmd.flush && pend_valid_q && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (gen) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush && out_free) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (gen) begin
			pend_q <= gen_res;
		end
		if (gen && pend_valid_q) begin
			out_q <= pend_q;
		end else if (cmd.flush && pend_valid_q && out_free) begin
			out_q             <= pend_q;
			out_q.last_of_run <= 1'b1;
		end
	end

	assign sts.can_gen    = can_gen;
	assign sts.pend_valid = pend_valid_q;
	assign sts.out_free   = out_free;
	assign sts.nx         = nx;
	assign out_valid      = out_valid_q;
	assign out_res        = out_q;

endmodule

### hdl/riff_wave_stream_decoder.sv
// ----------------------------------------------------------------------------
// riff_wave_stream_decoder
// A byte passes through accept, decode, end-of-file step and result flush.
// A chunk header adds a header check, a data header also two multiply steps;
// the last format byte and a chunk boundary each add a check step.
// Throughput is set by the per-byte controller sequence; a full output
// register stalls it. Reset is asynchronous and starts a new file.
// ----------------------------------------------------------------------------
module riff_wave_stream_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [15:0]          cfg_wr_data,
	rwsd_byte_if.sink            in_ch,
	rwsd_result_if.source        out_ch
);

	rwsd_pkg::cmd_t    cmd;
	rwsd_pkg::sts_t    sts;
	rwsd_pkg::result_t out_res;
	logic              out_valid;

	rwsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rwsd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.file_byte   (in_ch.file_byte),
		.is_last     (in_ch.is_last),
		.cmd         (cmd),
		.sts         (sts),
		.out_ready   (out_ch.ready),
		.out_valid   (out_valid),
		.out_res     (out_res)
	);

	assign out_ch.valid        = out_valid;
	assign out_ch.kind         = out_res.kind;
	assign out_ch.left_sample  = out_res.left_sample;
	assign out_ch.right_sample = out_res.right_sample;
	assign out_ch.is_float     = out_res.is_float;
	assign out_ch.error_code   = out_res.error_code;
	assign out_ch.frame_total  = out_res.frame_total;
	assign out_ch.sample_rate  = out_res.sample_rate;
	assign out_ch.last_of_run  = out_res.last_of_run;

`ifndef ASSERT_OFF
	a_one_byte_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("byte accepted while the previous one is in work");

	a_idle_nothing_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !sts.pend_valid)
		else $error("result still held while a new byte may enter");

	a_error_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.kind == rwsd_pkg::KIND_ERROR) |-> out_ch.last_of_run)
		else $error("error result is not the last of its beat");

	a_frame_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.kind == rwsd_pkg::KIND_FRAME) |->
		(out_ch.error_code == rwsd_pkg::ERR_NONE && out_ch.frame_total == 32'd0))
		else $error("frame result carries status fields");
`endif

endmodule
